### design/rbvq_pkg.sv
// ============================================================================
// rbvq_pkg
// Shared types and constants for the rotation-between-vectors quaternion unit
// ============================================================================
package rbvq_pkg;

    // one in Q30
    localparam logic [31:0] ONE_Q30   = 32'd1073741824;
    // -1 + 0.001 in Q30, as a magnitude
    localparam logic [30:0] OPP_LIMIT = 31'd1072668082;

    // pipeline advance and word valid, handed to each arithmetic unit
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    // three signed 16-bit components
    typedef logic [2:0][15:0] vec3_t;

    // riding along with the first square root
    typedef struct packed {
        logic [33:0]      dot;
        logic [2:0][32:0] cr;
        logic             zero;
    } side1_t;

    // riding along with the first divider
    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
    } side2_t;

    // riding along with the second square root
    typedef struct packed {
        logic [2:0][30:0] nm;
        logic [2:0]       nneg;
        logic             opp;
        logic             zero;
    } side3_t;

    // riding along with the second divider
    typedef struct packed {
        logic [2:0] nneg;
        logic       opp;
        logic       zero;
        logic [30:0] w30;
    } side4_t;

endpackage

### design/rbvq_div.sv
// ============================================================================
// rbvq_div
// Pipelined restoring divider, one quotient bit per stage, lanes share divisor
// ============================================================================
module rbvq_div
    import rbvq_pkg::*;
#(
    parameter int LANES = 1,
    parameter int NW    = 63,
    parameter int DW    = 32,
    parameter int QW    = 31,
    parameter int SW    = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pipe_ctl_t                   ctl,
    input  logic [DW-1:0]               in_den,
    input  logic [LANES-1:0][NW-1:0]    in_num,
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    out_quo,
    output logic [SW-1:0]               out_side
);

    localparam int WW = (DW + QW > NW) ? DW + QW : NW;

    logic                       valid_reg [1:QW];
    logic [LANES-1:0][QW-1:0]   quo_reg   [1:QW];
    logic [SW-1:0]              side_reg  [1:QW];
    logic [LANES-1:0][NW-1:0]   rem_reg   [1:QW-1];
    logic [DW-1:0]              den_reg   [1:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                     cur_valid;
        logic [DW-1:0]            cur_den;
        logic [LANES-1:0][NW-1:0] cur_rem;
        logic [LANES-1:0][QW-1:0] cur_quo;
        logic [SW-1:0]            cur_side;
        logic [LANES-1:0][NW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] quo_next;

        if (k == 0) begin : g_in
            assign cur_valid = ctl.valid;
            assign cur_den   = in_den;
            assign cur_rem   = in_num;
            assign cur_quo   = '0;
            assign cur_side  = in_side;
        end else begin : g_mid
            assign cur_valid = valid_reg[k];
            assign cur_den   = den_reg[k];
            assign cur_rem   = rem_reg[k];
            assign cur_quo   = quo_reg[k];
            assign cur_side  = side_reg[k];
        end

        // trial subtract of the shifted divisor
        always_comb begin
            logic [WW-1:0] dsh;
            logic [WW-1:0] rext;
            dsh = WW'(cur_den) << (QW - 1 - k);
            for (int l = 0; l < LANES; l++) begin
                rext = WW'(cur_rem[l]);
                if (rext >= dsh) begin
                    rem_next[l] = NW'(rext - dsh);
                    quo_next[l] = {cur_quo[l][QW-2:0], 1'b1};
                end else begin
                    rem_next[l] = cur_rem[l];
                    quo_next[l] = {cur_quo[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (ctl.en) begin
                valid_reg[k+1] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                quo_reg[k+1]  <= quo_next;
                side_reg[k+1] <= cur_side;
            end
        end

        if (k < QW - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (ctl.en) begin
                    rem_reg[k+1] <= rem_next;
                    den_reg[k+1] <= cur_den;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_quo   = quo_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

### design/rbvq_sqrt.sv
// ============================================================================
// rbvq_sqrt
// Pipelined digit-by-digit square root, one root bit per stage
// ============================================================================
module rbvq_sqrt
    import rbvq_pkg::*;
#(
    parameter int XW    = 64,
    parameter int SW    = 1,
    parameter bit ROUND = 1'b0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  pipe_ctl_t       ctl,
    input  logic [XW-1:0]   in_x,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [XW/2-1:0] out_root,
    output logic [SW-1:0]   out_side
);

    localparam int RW = XW / 2;

    logic          valid_reg [1:RW];
    logic [XW-1:0] rem_reg   [1:RW];
    logic [RW-1:0] root_reg  [1:RW];
    logic [SW-1:0] side_reg  [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          cur_valid;
        logic [XW-1:0] cur_rem;
        logic [RW-1:0] cur_root;
        logic [SW-1:0] cur_side;
        logic [XW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (k == 0) begin : g_in
            assign cur_valid = ctl.valid;
            assign cur_rem   = in_x;
            assign cur_root  = '0;
            assign cur_side  = in_side;
        end else begin : g_mid
            assign cur_valid = valid_reg[k];
            assign cur_rem   = rem_reg[k];
            assign cur_root  = root_reg[k];
            assign cur_side  = side_reg[k];
        end

        // try setting root bit: subtract (2r + 2^i) * 2^i
        always_comb begin
            logic [XW:0] cand;
            cand = ((XW+1)'(cur_root) << (RW - k)) | ((XW+1)'(1) << (2 * (RW - 1 - k)));
            if ((XW+1)'(cur_rem) >= cand) begin
                rem_next  = XW'((XW+1)'(cur_rem) - cand);
                root_next = cur_root | (RW'(1) << (RW - 1 - k));
            end else begin
                rem_next  = cur_rem;
                root_next = cur_root;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (ctl.en) begin
                valid_reg[k+1] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                side_reg[k+1] <= cur_side;
            end
        end
    end

    // optional round to nearest: remainder above root means step up
    always_comb begin
        logic up;
        up       = ROUND && (rem_reg[RW] > XW'(root_reg[RW]));
        out_root = root_reg[RW] + RW'(up);
    end

    assign out_valid = valid_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

### design/rotation_between_vectors_quat_unit.sv
// ============================================================================
// rotation_between_vectors_quat_unit
// Unit rotation quaternion that turns a start vector onto a destination vector
// ============================================================================
//
//  channel  ports       direction  contents
//  -------  ----------  ---------  -----------------------------------------
//  input    s_*         in         start_x/y/z, dest_x/y/z, signed 16 bit
//  result   m_*         out        quat_w/x/y/z Q(OUT_FRAC_BITS), two flags
//
//  one word enters per cycle while no result is held
//  the pipeline is the chain 64-bit root, 31-bit divide, 31-bit root and
//  35-bit divide, each one bit per stage, plus nine framing stages
//  reset (aresetn low, synchronous) clears every valid bit, no clearing pass
//  a held result stalls the whole pipeline in place; s_ready drops with it
//
module rotation_between_vectors_quat_unit
    import rbvq_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_start_x,
    input  logic signed [15:0] s_start_y,
    input  logic signed [15:0] s_start_z,
    input  logic signed [15:0] s_dest_x,
    input  logic signed [15:0] s_dest_y,
    input  logic signed [15:0] s_dest_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_quat_w,
    output logic signed [15:0] m_quat_x,
    output logic signed [15:0] m_quat_y,
    output logic signed [15:0] m_quat_z,
    output logic               m_near_opposite,
    output logic               m_zero_vector
);

    localparam int          SH   = 30 - OUT_FRAC_BITS;
    localparam int          SHM  = (SH > 0) ? SH - 1 : 0;
    localparam logic [31:0] RND  = (SH > 0) ? (32'd1 << SHM) : 32'd0;
    localparam logic [31:0] ONEO = 32'd1 << OUT_FRAC_BITS;
    localparam logic [14:0] WMAX = (ONEO > 32'd32767) ? 15'd32767 : 15'(ONEO);

    logic      en;
    logic      m_valid_reg;
    pipe_ctl_t ctl1, ctl2, ctl3, ctl4;

    // whole pipeline moves unless a finished word is held
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: input capture
    logic  v1_reg;
    vec3_t sa_reg, sb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg <= {s_start_z, s_start_y, s_start_x};
            sb_reg <= {s_dest_z, s_dest_y, s_dest_x};
        end
    end

    // doubling until the largest magnitude reaches 2^14, as one shift
    function automatic vec3_t prescale(input vec3_t v);
        logic [15:0] o;
        logic [3:0]  sh;
        vec3_t       r;
        o = '0;
        for (int i = 0; i < 3; i++) begin
            o = o | (v[i][15] ? 16'(16'd0 - v[i]) : v[i]);
        end
        sh = '0;
        for (int i = 0; i < 14; i++) begin
            if (o[i]) sh = 4'(14 - i);
        end
        if (o[15:14] != 2'b00) sh = '0;
        for (int i = 0; i < 3; i++) begin
            r[i] = v[i] << sh;
        end
        return r;
    endfunction

    // ---------------- stage 2: prescale and zero detect
    logic  v2_reg, zero2_reg;
    vec3_t pa_reg, pb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg    <= prescale(sa_reg);
            pb_reg    <= prescale(sb_reg);
            zero2_reg <= (sa_reg == '0) || (sb_reg == '0);
        end
    end

    // ---------------- stage 3: component products
    logic               v3_reg, zero3_reg;
    logic signed [31:0] aa_reg [3];
    logic signed [31:0] bb_reg [3];
    logic signed [31:0] dp_reg [3];
    logic signed [31:0] c1_reg [3];
    logic signed [31:0] c2_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero3_reg <= zero2_reg;
            for (int i = 0; i < 3; i++) begin
                aa_reg[i] <= $signed(pa_reg[i]) * $signed(pa_reg[i]);
                bb_reg[i] <= $signed(pb_reg[i]) * $signed(pb_reg[i]);
                dp_reg[i] <= $signed(pa_reg[i]) * $signed(pb_reg[i]);
            end
            c1_reg[0] <= $signed(pa_reg[1]) * $signed(pb_reg[2]);
            c1_reg[1] <= $signed(pa_reg[2]) * $signed(pb_reg[0]);
            c1_reg[2] <= $signed(pa_reg[0]) * $signed(pb_reg[1]);
            c2_reg[0] <= $signed(pa_reg[2]) * $signed(pb_reg[1]);
            c2_reg[1] <= $signed(pa_reg[0]) * $signed(pb_reg[2]);
            c2_reg[2] <= $signed(pa_reg[1]) * $signed(pb_reg[0]);
        end
    end

    // ---------------- stage 4: squared norms, dot and cross
    logic               v4_reg, zero4_reg;
    logic [31:0]        asum_reg, bsum_reg;
    logic signed [33:0] dot_reg;
    logic [2:0][32:0]   cr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero4_reg <= zero3_reg;
            asum_reg  <= 32'(aa_reg[0]) + 32'(aa_reg[1]) + 32'(aa_reg[2]);
            bsum_reg  <= 32'(bb_reg[0]) + 32'(bb_reg[1]) + 32'(bb_reg[2]);
            dot_reg   <= 34'(dp_reg[0]) + 34'(dp_reg[1]) + 34'(dp_reg[2]);
            for (int i = 0; i < 3; i++) begin
                cr_reg[i] <= 33'(c1_reg[i]) - 33'(c2_reg[i]);
            end
        end
    end

    // ---------------- stage 5: product of squared norms
    logic        v5_reg;
    logic [63:0] abp_reg;
    side1_t      side5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            abp_reg        <= 64'(asum_reg) * 64'(bsum_reg);
            side5_reg.dot  <= dot_reg;
            side5_reg.cr   <= cr_reg;
            side5_reg.zero <= zero4_reg;
        end
    end

    // ---------------- L = floor(sqrt(|a|^2 |b|^2))
    logic        sq1_valid;
    logic [31:0] sq1_root;
    side1_t      sq1_side;

    assign ctl1 = '{en: en, valid: v5_reg};

    rbvq_sqrt #(.XW(64), .SW($bits(side1_t)), .ROUND(1'b0)) u_sqrt_len (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl1),
        .in_x     (abp_reg),
        .in_side  (side5_reg),
        .out_valid(sq1_valid),
        .out_root (sq1_root),
        .out_side (sq1_side)
    );

    // ---------------- stage 6: rounded numerators for c and n
    logic             v6_reg;
    logic [3:0][62:0] num6_reg;
    logic [31:0]      den6_reg;
    side2_t           side6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= sq1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic [33:0] dm;
        logic [32:0] cm;
        if (en) begin
            dm = sq1_side.dot[33] ? 34'(34'd0 - sq1_side.dot) : sq1_side.dot;
            num6_reg[0]  <= 63'({dm[31:0], 30'd0}) + 63'(sq1_root >> 1);
            side6_reg.neg[0] <= sq1_side.dot[33];
            for (int i = 0; i < 3; i++) begin
                cm = sq1_side.cr[i][32] ? 33'(33'd0 - sq1_side.cr[i]) : sq1_side.cr[i];
                num6_reg[i+1]      <= 63'({cm[31:0], 30'd0}) + 63'(sq1_root >> 1);
                side6_reg.neg[i+1] <= sq1_side.cr[i][32];
            end
            den6_reg       <= sq1_root;
            side6_reg.zero <= sq1_side.zero;
        end
    end

    // ---------------- c and n over L
    logic             dv1_valid;
    logic [3:0][30:0] dv1_quo;
    side2_t           dv1_side;

    assign ctl2 = '{en: en, valid: v6_reg};

    rbvq_div #(.LANES(4), .NW(63), .DW(32), .QW(31), .SW($bits(side2_t))) u_div_len (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl2),
        .in_den   (den6_reg),
        .in_num   (num6_reg),
        .in_side  (side6_reg),
        .out_valid(dv1_valid),
        .out_quo  (dv1_quo),
        .out_side (dv1_side)
    );

    // ---------------- stage 7: clamp, near-opposite rule, u = 1 + c
    logic        v7_reg;
    logic [31:0] u7_reg;
    side3_t      side7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= dv1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic [30:0] cmag;
        logic        opp;
        if (en) begin
            cmag = (dv1_quo[0] > ONE_Q30[30:0]) ? ONE_Q30[30:0] : dv1_quo[0];
            opp  = dv1_side.neg[0] && (cmag > OPP_LIMIT);
            if (opp) begin
                u7_reg <= ONE_Q30;
            end else if (dv1_side.neg[0]) begin
                u7_reg <= ONE_Q30 - 32'(cmag);
            end else begin
                u7_reg <= ONE_Q30 + 32'(cmag);
            end
            for (int i = 0; i < 3; i++) begin
                side7_reg.nm[i] <= (dv1_quo[i+1] > ONE_Q30[30:0]) ? ONE_Q30[30:0]
                                                                   : dv1_quo[i+1];
                side7_reg.nneg[i] <= dv1_side.neg[i+1];
            end
            side7_reg.opp  <= opp;
            side7_reg.zero <= dv1_side.zero;
        end
    end

    // ---------------- w30 = round(sqrt(u * 2^29))
    logic        sq2_valid;
    logic [30:0] sq2_root;
    side3_t      sq2_side;

    assign ctl3 = '{en: en, valid: v7_reg};

    rbvq_sqrt #(.XW(62), .SW($bits(side3_t)), .ROUND(1'b1)) u_sqrt_half (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl3),
        .in_x     (62'(u7_reg) << 29),
        .in_side  (side7_reg),
        .out_valid(sq2_valid),
        .out_root (sq2_root),
        .out_side (sq2_side)
    );

    // ---------------- stage 8: rounded numerators n * 2^29
    logic             v8_reg;
    logic [2:0][59:0] num8_reg;
    side4_t           side8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= sq2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num8_reg[i] <= (60'(sq2_side.nm[i]) << 29) + 60'(sq2_root >> 1);
            end
            side8_reg.nneg <= sq2_side.nneg;
            side8_reg.opp  <= sq2_side.opp;
            side8_reg.zero <= sq2_side.zero;
            side8_reg.w30  <= sq2_root;
        end
    end

    // ---------------- vector part over w30
    logic             dv2_valid;
    logic [2:0][34:0] dv2_quo;
    side4_t           dv2_side;

    assign ctl4 = '{en: en, valid: v8_reg};

    rbvq_div #(.LANES(3), .NW(60), .DW(31), .QW(35), .SW($bits(side4_t))) u_div_half (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl4),
        .in_den   (side8_reg.w30),
        .in_num   (num8_reg),
        .in_side  (side8_reg),
        .out_valid(dv2_valid),
        .out_quo  (dv2_quo),
        .out_side (dv2_side)
    );

    // ---------------- stage 9: output rounding, saturation, output word
    logic [14:0]       m_quat_w_reg;
    logic [2:0][15:0]  m_quat_v_reg;
    logic              m_opp_reg, m_zero_reg;
    logic [14:0]       w_next;
    logic [2:0][15:0]  v_next;

    always_comb begin
        logic [30:0] qm;
        logic [31:0] rm;
        rm     = (32'(dv2_side.w30) + RND) >> SH;
        w_next = (rm > 32'd32767) ? 15'd32767 : 15'(rm);
        for (int i = 0; i < 3; i++) begin
            qm = (dv2_quo[i] > 35'(ONE_Q30)) ? ONE_Q30[30:0] : 31'(dv2_quo[i]);
            rm = (32'(qm) + RND) >> SH;
            if (!dv2_side.nneg[i]) begin
                v_next[i] = (rm > 32'd32767) ? 16'h7FFF : 16'(rm);
            end else begin
                v_next[i] = (rm > 32'd32768) ? 16'h8000 : 16'(32'd0 - rm);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (dv2_side.zero) begin
                m_quat_w_reg <= WMAX;
                m_quat_v_reg <= '0;
                m_opp_reg    <= 1'b0;
            end else begin
                m_quat_w_reg <= w_next;
                m_quat_v_reg <= v_next;
                m_opp_reg    <= dv2_side.opp;
            end
            m_zero_reg <= dv2_side.zero;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_quat_w        = m_quat_w_reg;
    assign m_quat_x        = m_quat_v_reg[0];
    assign m_quat_y        = m_quat_v_reg[1];
    assign m_quat_z        = m_quat_v_reg[2];
    assign m_near_opposite = m_opp_reg;
    assign m_zero_vector   = m_zero_reg;

    // ---------------- checks
    a_zero_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_vector |->
            m_quat_x == 16'sd0 && m_quat_y == 16'sd0 && m_quat_z == 16'sd0 &&
            !m_near_opposite && m_quat_w == WMAX)
        else $error("zero-length word is not the identity");

    a_held_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while a result is held");

    a_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_quat_w <= WMAX)
        else $error("scalar part above one");

    a_hold_pipeline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_quat_w) && $stable(m_quat_v_reg))
        else $error("held result changed");

endmodule

### dv/rbvq_checker.sv
// ============================================================================
// rbvq_checker
// Watches both channels of the quaternion unit, predicts each result word
// from the accepted input word and compares field by field, in order
// ============================================================================
module rbvq_checker #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_start_x,
    input  logic signed [15:0] s_start_y,
    input  logic signed [15:0] s_start_z,
    input  logic signed [15:0] s_dest_x,
    input  logic signed [15:0] s_dest_y,
    input  logic signed [15:0] s_dest_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [14:0]        m_quat_w,
    input  logic signed [15:0] m_quat_x,
    input  logic signed [15:0] m_quat_y,
    input  logic signed [15:0] m_quat_z,
    input  logic               m_near_opposite,
    input  logic               m_zero_vector,
    output int                 fail_count,
    output int                 pending_count,
    output int                 words_out,
    output int                 opp_seen,
    output int                 zero_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q30_ONE   = 64'sd1 << 30;
    localparam longint OPP_BOUND = 64'sd1072668082;

    typedef struct packed {
        logic [14:0]        w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               opp;
        logic               zero;
    } quat_t;

    quat_t quat_queue[$];

    // integer square root, floor
    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // signed divide, rounded half away from zero
    function automatic longint div_round(longint num, longint unsigned den);
        longint unsigned m, q;
        m = (num < 0) ? longint'(-num) : longint'(num);
        q = (m + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q30 down to output fraction bits, half away from zero
    function automatic longint q30_to_out(longint v);
        longint unsigned m;
        int sh;
        sh = 30 - OUT_FRAC_BITS;
        m = (v < 0) ? longint'(-v) : longint'(v);
        if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // double a vector until its largest component reaches 2^14
    function automatic void normalize_up(ref longint v[3]);
        longint unsigned m;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            if ((v[i] < 0 ? -v[i] : v[i]) > m) m = (v[i] < 0 ? -v[i] : v[i]);
        end
        while (m != 0 && m < 16384) begin
            for (int i = 0; i < 3; i++) v[i] *= 2;
            m <<= 1;
        end
    endfunction

    function automatic quat_t rotation_quat(longint a[3], longint b[3]);
        quat_t r;
        longint cr[3], c, nv, qv;
        longint unsigned la, lb, len, u, sq, w30;
        r = '0;
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) ||
            (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
            r.w    = 15'(clip(q30_to_out(Q30_ONE), 0, 32767));
            r.zero = 1'b1;
            return r;
        end
        normalize_up(a);
        normalize_up(b);
        la  = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        lb  = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        len = sqrt_floor(la * lb);
        if (len == 0) len = 1;
        cr[0] = a[1] * b[2] - a[2] * b[1];
        cr[1] = a[2] * b[0] - a[0] * b[2];
        cr[2] = a[0] * b[1] - a[1] * b[0];
        c = div_round((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) * Q30_ONE, len);
        c = clip(c, -Q30_ONE, Q30_ONE);
        // near-opposite directions: cosine forced to zero
        if (c < -OPP_BOUND) begin
            c = 0;
            r.opp = 1'b1;
        end
        u   = Q30_ONE + c;
        sq  = u << 29;
        w30 = sqrt_floor(sq);
        if (sq - w30 * w30 > w30) w30++;
        for (int i = 0; i < 3; i++) begin
            nv = clip(div_round(cr[i] * Q30_ONE, len), -Q30_ONE, Q30_ONE);
            qv = (w30 == 0) ? 0 :
                 clip(div_round(nv * (64'sd1 << 29), w30), -Q30_ONE, Q30_ONE);
            qv = clip(q30_to_out(qv), -32768, 32767);
            if (i == 0) r.x = 16'(qv);
            else if (i == 1) r.y = 16'(qv);
            else r.z = 16'(qv);
        end
        r.w = 15'(clip(q30_to_out(longint'(w30)), 0, 32767));
        return r;
    endfunction

    assign pending_count = quat_queue.size();

    // predict on input words, compare on result words
    always @(posedge aclk) begin
        longint a[3], b[3];
        quat_t exp_q, got;
        if (!aresetn) begin
            quat_queue.delete();
            fail_count <= 0;
            words_out  <= 0;
            opp_seen   <= 0;
            zero_seen  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                a = '{s_start_x, s_start_y, s_start_z};
                b = '{s_dest_x, s_dest_y, s_dest_z};
                quat_queue.insert(quat_queue.size(), rotation_quat(a, b));
            end
            if (m_valid && m_ready) begin
                got = '{m_quat_w, m_quat_x, m_quat_y, m_quat_z,
                        m_near_opposite, m_zero_vector};
                words_out <= words_out + 1;
                if (quat_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("error: result word with none expected: %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_q = quat_queue.pop_front();
                    if (exp_q.opp) opp_seen <= opp_seen + 1;
                    if (exp_q.zero) zero_seen <= zero_seen + 1;
                    if (got !== exp_q) begin
                        if (fail_count < 10)
                            $display("error: mismatch exp w=%0d x=%0d y=%0d z=%0d opp=%0d zero=%0d got w=%0d x=%0d y=%0d z=%0d opp=%0d zero=%0d",
                                exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.opp, exp_q.zero,
                                got.w, got.x, got.y, got.z, got.opp, got.zero);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### dv/rotation_between_vectors_quat_unit_tb.sv
// ============================================================================
// rotation_between_vectors_quat_unit_tb
// Drives directed and random vector pairs into the quaternion unit with
// random gaps and stalls; a checker beside the block predicts every result
// ============================================================================
module rotation_between_vectors_quat_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1830;
    localparam int LATENCY   = 138;
    localparam longint MAX_CYCLES = 2000000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_start_x = '0, s_start_y = '0, s_start_z = '0;
    logic signed [15:0] s_dest_x = '0, s_dest_y = '0, s_dest_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [14:0]        m_quat_w;
    logic signed [15:0] m_quat_x, m_quat_y, m_quat_z;
    logic               m_near_opposite, m_zero_vector;
    int                 fail_count, pending_count, words_out, opp_seen, zero_seen;
    int                 words_in = 0;
    longint             cycle = 0;
    bit                 stim_done = 1'b0;

    always #5 aclk = ~aclk;

    rotation_between_vectors_quat_unit i_dut (.*);

    rbvq_checker i_checker (.*);

    // short gaps mostly, an occasional long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // random component, weighted toward extremes and small values
    function automatic logic [15:0] comp_val();
        unique case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 6)) - 3);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // timeout guard
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side stalls at random
    always @(posedge aclk) begin
        int hold;
        if (aresetn) begin
            if (hold > 0) begin
                hold = hold - 1;
                m_ready <= 1'b0;
            end else begin
                hold = gap_len();
                m_ready <= (hold == 0);
            end
        end
    end

    // valid stays high into the next word when there is no gap
    task automatic send_word(input logic [15:0] sx, sy, sz, dx, dy, dz);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_start_x <= sx; s_start_y <= sy; s_start_z <= sz;
        s_dest_x  <= dx; s_dest_y  <= dy; s_dest_z  <= dz;
        do @(posedge aclk); while (!s_ready);
        words_in++;
    endtask

    // stop sending and wait until every expected word has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_count == 0);
        @(posedge aclk);
    endtask

    initial begin
        logic [15:0] v[6];
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero vectors, extremes, parallel, opposite, orthogonal
        send_word(0, 0, 0, 100, 0, 0);
        send_word(5, 6, 7, 0, 0, 0);
        send_word(0, 0, 0, 0, 0, 0);
        send_word(16'h7fff, 0, 0, 16'h7fff, 0, 0);
        send_word(16'h7fff, 0, 0, 16'h8000, 0, 0);
        send_word(1, 0, 0, -1, 0, 0);
        send_word(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_word(1, 0, 0, 0, 1, 0);
        send_word(0, 1, 0, 0, 0, 1);
        send_word(0, 0, 1, 1, 0, 0);
        send_word(1000, 20, 0, -1000, -21, 0);
        send_word(1000, 0, 0, -1000, 40, 0);
        send_word(1, 1, 1, -1, -1, -1);
        send_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_word(16'h8000, 16'h7fff, 1, 16'h7fff, 16'h8000, -1);
        send_word(3, 4, 0, 4, 3, 0);
        send_word(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_word(1, 0, 0, 1, 0, 0);

        // hold off until the pipeline drains
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            for (int j = 0; j < 6; j++) v[j] = comp_val();
            k = $urandom_range(0, 9);
            // near-opposite pairs: negate with a small perturbation
            if (k < 2) begin
                for (int j = 0; j < 3; j++)
                    v[j + 3] = 16'(-$signed(v[j]) + $signed($urandom_range(0, 4)) - 2);
            end else if (k == 2) begin
                for (int j = 0; j < 3; j++) v[j + 3] = v[j];
            end
            send_word(v[0], v[1], v[2], v[3], v[4], v[5]);
            if (i == N_RANDOM / 2) drain();
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        stim_done = 1'b1;
    end

    // verdict once everything has drained
    initial begin
        wait (stim_done);
        wait (pending_count == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("covered %0d input words and %0d result words", words_in, words_out);
        $display("%0d near-opposite and %0d zero-length cases checked", opp_seen, zero_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
